@@ hw/rtl/fribe_pkg.sv @@
// Shared types and constants for the frame ring buffer with oldest-frame eviction.
// No dependencies; imported by the interfaces and the unit module (fribe_ram does not use it).
package fribe_pkg;

  localparam int LEN_W  = 15;
  localparam int TS_W   = 32;
  localparam int STAT_W = 2;
  localparam int EVC_W  = 14;
  localparam int USED_W = 16;
  // Width of the eviction arithmetic: 32-bit stored length plus header, with margin.
  localparam int EV_W   = 34;
  // Header bytes that carry length and time; the rest of a header is zero fill.
  localparam int HDR_DATA_BYTES = 8;

  localparam logic MODE_BEGIN   = 1'b0;
  localparam logic MODE_PAYLOAD = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_CORRUPT   = 2'd2;

  typedef struct packed {
    logic              mode;
    logic              channel;
    logic [LEN_W-1:0]  frame_length;
    logic [TS_W-1:0]   time_stamp;
    logic [7:0]        payload_byte;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [EVC_W-1:0]  evicted_frames;
    logic [TS_W-1:0]   oldest_time;
    logic [TS_W-1:0]   newest_time;
    logic [USED_W-1:0] used_bytes;
  } result_t;

endpackage

@@ hw/rtl/fribe_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on fribe_pkg for the payload types.
interface fribe_item_if;
  import fribe_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface fribe_result_if;
  import fribe_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/fribe_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module fribe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ hw/rtl/frame_ring_buffer_evict_oldest_unit.sv @@
// Payload item: accepted and written in the same cycle while idle, one per cycle back to back.
// Begin item: a check step, then per evicted frame the reads of the 8 header bytes on the
// single RAM port plus one update step, a write of HEADER_BYTES header bytes, a pointer
// update and a result load when accepted; a check and a result load when rejected; a
// corrupt header skips to the result load; a result not yet taken holds the next item.
// Reset (synchronous) clears pointers, stamps and flags; ring RAM stays undefined.
module frame_ring_buffer_evict_oldest_unit #(
  parameter int BUF_BYTES    = 65536,
  parameter int HEADER_BYTES = 8,
  parameter int MAX_FRAME    = 16384,
  parameter int CHANNELS     = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  fribe_item_if.sink            item,
  fribe_result_if.source        result
);
  import fribe_pkg::*;

  localparam int PW = $clog2(BUF_BYTES);
  localparam int UW = $clog2(BUF_BYTES + 1);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW = $clog2(CHANNELS * BUF_BYTES);
  localparam int HW = $clog2(HEADER_BYTES);
  localparam logic [EV_W-1:0] BUF_E  = EV_W'(BUF_BYTES);
  localparam logic [EV_W-1:0] HDR_E  = EV_W'(HEADER_BYTES);
  localparam logic [EV_W-1:0] MAXF_E = EV_W'(MAX_FRAME);
  localparam logic [HW-1:0]   HDR_LAST = HW'(HEADER_BYTES - 1);
  localparam logic [3:0]      RD_LAST  = 4'(HDR_DATA_BYTES);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CHK  = 7'b0000010,
    S_RD   = 7'b0000100,
    S_EV   = 7'b0001000,
    S_WR   = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;

  // Per-channel pointer file.
  logic [PW-1:0]       wp     [CHANNELS];
  logic [PW-1:0]       rp     [CHANNELS];
  logic [TS_W-1:0]     old_ts [CHANNELS];
  logic [TS_W-1:0]     new_ts [CHANNELS];
  logic [CHANNELS-1:0] rv;

  logic [LEN_W-1:0]  pay_rem;
  logic              dropping;

  // Begin item in flight.
  logic [CW-1:0]     cur_ch;
  logic              cur_bad;
  logic [LEN_W-1:0]  cur_len;
  logic [TS_W-1:0]   cur_ts;
  logic [STAT_W-1:0] cur_status;
  logic [EVC_W-1:0]  ev_cnt;
  logic [EV_W-1:0]   ev_used;
  logic [EV_W-1:0]   ev_release;
  logic [EV_W-1:0]   ev_moved;
  logic [3:0]        rk;
  logic [63:0]       hdr;
  logic [HW-1:0]     wk;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                             input logic [EV_W-1:0] b);
    logic [EV_W-1:0] s;
    s = EV_W'(a) + b;
    if (s >= BUF_E) s = s - BUF_E;
    return s[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] ch,
                                            input logic [EV_W-1:0] pos);
    logic [EV_W-1:0] t;
    t = EV_W'(ch) * BUF_E + pos;
    return t[AW-1:0];
  endfunction

  // Channel select: the input channel while idle, the held one otherwise.
  logic [CW-1:0]   in_ch, sel_ch;
  logic            in_bad;
  logic [PW-1:0]   s_wp, s_rp;
  logic            s_rv;
  logic [UW-1:0]   s_used;
  logic [EV_W-1:0] need, needed, free_b, pay_pos, wpe, reme, ev_size, used_n, moved_n;
  logic [2:0]      cap_idx;
  logic [63:0]     hdr_wr;
  logic [UW+USED_W-1:0] used_ext;

  assign in_ch  = CW'(item.data.channel);
  assign in_bad = (32'(item.data.channel) >= 32'(CHANNELS));
  assign sel_ch = (state == S_IDLE) ? in_ch : cur_ch;
  assign s_wp   = wp[sel_ch];
  assign s_rp   = rp[sel_ch];
  assign s_rv   = rv[sel_ch];

  always_comb begin
    if (!s_rv) s_used = '0;
    else if (s_rp < s_wp) s_used = UW'(s_wp) - UW'(s_rp);
    else s_used = UW'(BUF_BYTES) - (UW'(s_rp) - UW'(s_wp));
  end
  assign used_ext = {{USED_W{1'b0}}, s_used};

  assign need    = HDR_E + EV_W'(cur_len);
  assign needed  = need + HDR_E;
  assign free_b  = BUF_E - EV_W'(s_used);
  // Payload byte lands at write pointer minus remaining count, modulo ring size.
  assign wpe     = EV_W'(s_wp);
  assign reme    = EV_W'(pay_rem);
  assign pay_pos = (wpe >= reme) ? (wpe - reme) : (wpe + BUF_E - reme);
  assign ev_size = HDR_E + EV_W'(hdr[31:0]);
  assign used_n  = ev_used - ev_size;
  assign moved_n = ev_moved + ev_size;
  assign cap_idx = 3'(rk - 4'd1);
  assign hdr_wr  = {cur_ts, {(32 - LEN_W){1'b0}}, cur_len};

  assign item.ready = (state == S_IDLE);

  // Single RAM port: payload writes while idle, header reads, header writes.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    unique case (state)
      S_IDLE: begin
        ram_addr  = addr_of(in_ch, pay_pos);
        ram_wdata = item.data.payload_byte;
        ram_we    = item.valid && (item.data.mode == MODE_PAYLOAD) && (pay_rem != '0)
                    && !dropping && !in_bad;
      end
      S_RD: begin
        ram_addr = addr_of(cur_ch, EV_W'(wrap_add(s_rp, EV_W'(rk))));
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_addr  = addr_of(cur_ch, EV_W'(wrap_add(s_wp, EV_W'(wk))));
        ram_wdata = (32'(wk) < 32'(HDR_DATA_BYTES)) ? hdr_wr[{wk[2:0], 3'b000} +: 8] : 8'd0;
      end
      default: ;
    endcase
  end

  fribe_ram #(
    .WIDTH(8),
    .DEPTH(CHANNELS * BUF_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rv           <= '0;
      pay_rem      <= '0;
      dropping     <= 1'b0;
      result.valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wp[i]     <= '0;
        rp[i]     <= '0;
        old_ts[i] <= '0;
        new_ts[i] <= '0;
      end
    end else begin
      // Drop the result once taken; S_DONE loads the next one instead.
      if (result.valid && result.ready && state != S_DONE) result.valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            if (item.data.mode == MODE_PAYLOAD) begin
              // Advance over the reserved space; a stray byte is ignored.
              if (pay_rem != '0) begin
                pay_rem <= pay_rem - 1'b1;
                if (pay_rem == LEN_W'(1)) dropping <= 1'b0;
              end
            end else begin
              // A new frame abandons whatever payload was still expected.
              cur_ch     <= in_ch;
              cur_bad    <= in_bad;
              cur_len    <= item.data.frame_length;
              cur_ts     <= item.data.time_stamp;
              cur_status <= ST_OK;
              ev_cnt     <= '0;
              pay_rem    <= item.data.frame_length;
              dropping   <= (item.data.frame_length != '0);
              state      <= S_CHK;
            end
          end
        end

        S_CHK: begin
          if (cur_bad || (EV_W'(cur_len) > MAXF_E) || (needed >= BUF_E)) begin
            cur_status <= ST_TOO_LARGE;
            state      <= S_DONE;
          end else if (s_rv && (free_b < needed)) begin
            ev_used    <= EV_W'(s_used);
            ev_release <= needed - free_b;
            ev_moved   <= '0;
            rk         <= '0;
            state      <= S_RD;
          end else begin
            wk    <= '0;
            state <= S_WR;
          end
        end

        S_RD: begin
          // Read data arrives in the cycle after its address.
          if (rk != '0) hdr[{cap_idx, 3'b000} +: 8] <= ram_rdata;
          if (rk == RD_LAST) state <= S_EV;
          else rk <= rk + 1'b1;
        end

        S_EV: begin
          if (ev_size > ev_used) begin
            cur_status <= ST_CORRUPT;
            state      <= S_DONE;
          end else begin
            old_ts[cur_ch] <= hdr[63:32];
            rp[cur_ch]     <= wrap_add(s_rp, ev_size);
            ev_used        <= used_n;
            ev_moved       <= moved_n;
            ev_cnt         <= ev_cnt + 1'b1;
            if (moved_n >= ev_release) begin
              if (used_n == '0) rv[cur_ch] <= 1'b0;
              wk    <= '0;
              state <= S_WR;
            end else begin
              rk    <= '0;
              state <= S_RD;
            end
          end
        end

        S_WR: begin
          if (wk == HDR_LAST) state <= S_FIN;
          else wk <= wk + 1'b1;
        end

        S_FIN: begin
          // Empty ring: this frame becomes the oldest.
          if (!s_rv) begin
            rv[cur_ch]     <= 1'b1;
            rp[cur_ch]     <= s_wp;
            old_ts[cur_ch] <= cur_ts;
          end
          wp[cur_ch]     <= wrap_add(s_wp, need);
          new_ts[cur_ch] <= cur_ts;
          dropping       <= 1'b0;
          state          <= S_DONE;
        end

        S_DONE: begin
          // Hold until the output register is free.
          if (!result.valid || result.ready) begin
            result.valid               <= 1'b1;
            result.data.status         <= cur_status;
            result.data.evicted_frames <= ev_cnt;
            result.data.oldest_time    <= cur_bad ? '0 : old_ts[cur_ch];
            result.data.newest_time    <= cur_bad ? '0 : new_ts[cur_ch];
            result.data.used_bytes     <= cur_bad ? '0 : used_ext[USED_W-1:0];
            state                      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_ram_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE || state == S_WR))
    else $error("ring written outside payload or header write");

  a_reject_no_evict: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && cur_status == ST_TOO_LARGE) |-> (ev_cnt == '0))
    else $error("rejected frame evicted data");

  a_drop_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && pay_rem == '0) |-> !dropping)
    else $error("drop flag left set with no payload pending");

  a_evict_progress: assert property (@(posedge clk) disable iff (rst)
    (state == S_EV && ev_size <= ev_used) |=> (ev_cnt == $past(ev_cnt) + 1'b1))
    else $error("eviction did not count a frame");
endmodule
